FILE: hw/rtl/sv39ptw_pkg.sv
// Shared types and codes for the Sv39 page table walker.
package sv39ptw_pkg;

  // Widths fixed by the Sv39 format.
  localparam int unsigned VA_W    = 39;
  localparam int unsigned PPN_W   = 44;
  localparam int unsigned PA_W    = 56;
  localparam int unsigned PTE_W   = 64;
  localparam int unsigned LEVEL_W = 2;

  // Request kinds on the input channel.
  typedef enum logic {
    MODE_TRANSLATE = 1'b0,
    MODE_RESPONSE  = 1'b1
  } mode_t;

  // Result kinds on the output channel.
  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_FAULT = 2'd2
  } kind_t;

  // Level at which every walk starts.
  localparam logic [LEVEL_W-1:0] TOP_LEVEL = 2'd2;

  // A request after classification by the front end.
  typedef struct packed {
    mode_t             mode;
    logic [VA_W-1:0]   vaddr;
    logic              pte_v;
    logic              pte_leaf;
    logic [PPN_W-1:0]  pte_ppn;
  } cmd_t;

endpackage

FILE: hw/rtl/sv39ptw_if.sv
// Channel interfaces of the page table walker: requests, results and configuration.
interface sv39ptw_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [38:0] virtual_address;
  logic [63:0] pte_word;

  modport source (output valid, output mode, output virtual_address, output pte_word,
                  input ready);
  modport sink   (input valid, input mode, input virtual_address, input pte_word,
                  output ready);
endinterface

interface sv39ptw_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [55:0] address;
  logic [1:0]  leaf_level;

  modport source (output valid, output kind, output address, output leaf_level,
                  input ready);
  modport sink   (input valid, input kind, input address, input leaf_level,
                  output ready);
endinterface

interface sv39ptw_cfg_if;
  logic        valid;
  logic        ready;
  logic [43:0] root_table_ppn;

  modport source (output valid, output root_table_ppn, input ready);
  modport sink   (input valid, input root_table_ppn, output ready);
endinterface

FILE: hw/rtl/sv39ptw_front.sv
// Front end: takes requests and decodes them into walk commands.
module sv39ptw_front
  import sv39ptw_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  sv39ptw_in_if.sink    in_req,
  output logic          cmd_valid,
  output cmd_t          cmd,
  input  logic          cmd_ready
);

  logic  valid_r, valid_nxt;
  cmd_t  cmd_r, cmd_nxt;
  logic  take;

  // A new request may enter whenever the stage is empty or drains this cycle.
  assign in_req.ready = !valid_r || cmd_ready;
  assign take         = in_req.valid && in_req.ready;

  // Decode the entry bits the back end needs: V, any of R/W/X, and the PPN.
  always_comb begin
    cmd_nxt = cmd_r;
    if (take) begin
      cmd_nxt.mode     = mode_t'(in_req.mode);
      cmd_nxt.vaddr    = in_req.virtual_address;
      cmd_nxt.pte_v    = in_req.pte_word[0];
      cmd_nxt.pte_leaf = |in_req.pte_word[3:1];
      cmd_nxt.pte_ppn  = in_req.pte_word[53:10];
    end
    valid_nxt = take || (valid_r && !cmd_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    cmd_r <= cmd_nxt;
  end

  assign cmd_valid = valid_r;
  assign cmd       = cmd_r;

endmodule

FILE: hw/rtl/sv39ptw_queue.sv
// Short command queue between the front end and the walk engine.
module sv39ptw_queue
  import sv39ptw_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push_valid,
  input  cmd_t  push_cmd,
  output logic  push_ready,
  output logic  pop_valid,
  output cmd_t  pop_cmd,
  input  logic  pop_ready
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push, pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_cmd    = mem[rd_ptr_r];

  // Pointer and occupancy update; pointers wrap at the queue depth.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage write.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

FILE: hw/rtl/sv39ptw_back.sv
// Walk engine: holds the walk state, steps it per command and registers the result.
module sv39ptw_back
  import sv39ptw_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  input  cmd_t          cmd,
  output logic          cmd_ready,
  sv39ptw_cfg_if.sink   cfg_wr,
  sv39ptw_out_if.source out_res
);

  // Index bits of one level of the virtual page number.
  function automatic logic [8:0] vpn_of(input logic [VA_W-1:0] va,
                                        input logic [LEVEL_W-1:0] lvl);
    logic [8:0] vpn;
    case (lvl)
      2'd0:    vpn = va[20:12];
      2'd1:    vpn = va[29:21];
      default: vpn = va[38:30];
    endcase
    return vpn;
  endfunction

  logic [PPN_W-1:0]   root_r;
  logic               busy_r, busy_nxt;
  logic [VA_W-1:0]    vaddr_r, vaddr_nxt;
  logic [LEVEL_W-1:0] level_r, level_nxt;

  logic               out_valid_r, out_valid_nxt;
  kind_t              out_kind_r, out_kind_nxt;
  logic [PA_W-1:0]    out_addr_r, out_addr_nxt;
  logic [LEVEL_W-1:0] out_lvl_r, out_lvl_nxt;

  logic               slot_free;
  logic               emit;
  logic               pop;
  kind_t              res_kind;
  logic [PA_W-1:0]    res_addr;
  logic [LEVEL_W-1:0] res_lvl;
  logic [LEVEL_W-1:0] cur_lvl;

  // Configuration is always taken.
  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_r <= '0;
    end else if (cfg_wr.valid) begin
      root_r <= cfg_wr.root_table_ppn;
    end
  end

  assign cur_lvl = (level_r > TOP_LEVEL) ? TOP_LEVEL : level_r;

  // One walk step per command.
  always_comb begin
    busy_nxt  = busy_r;
    vaddr_nxt = vaddr_r;
    level_nxt = level_r;
    emit      = 1'b0;
    res_kind  = KIND_FAULT;
    res_addr  = '0;
    res_lvl   = '0;
    if (cmd.mode == MODE_TRANSLATE) begin
      // A translate request during a walk is dropped.
      if (!busy_r) begin
        emit      = 1'b1;
        res_kind  = KIND_READ;
        res_addr  = {root_r, vpn_of(cmd.vaddr, TOP_LEVEL), 3'b000};
        vaddr_nxt = cmd.vaddr;
        level_nxt = TOP_LEVEL;
        busy_nxt  = 1'b1;
      end
    end else if (busy_r) begin
      emit = 1'b1;
      if (!cmd.pte_v) begin
        res_kind  = KIND_FAULT;
        busy_nxt  = 1'b0;
        level_nxt = TOP_LEVEL;
      end else if (cmd.pte_leaf) begin
        // Superpages take more of their offset from the virtual address.
        res_kind = KIND_DONE;
        res_lvl  = cur_lvl;
        case (cur_lvl)
          2'd0:    res_addr = {cmd.pte_ppn, vaddr_r[11:0]};
          2'd1:    res_addr = {cmd.pte_ppn[43:9], vaddr_r[20:0]};
          default: res_addr = {cmd.pte_ppn[43:18], vaddr_r[29:0]};
        endcase
        busy_nxt  = 1'b0;
        level_nxt = TOP_LEVEL;
      end else if (cur_lvl == '0) begin
        res_kind  = KIND_FAULT;
        busy_nxt  = 1'b0;
        level_nxt = TOP_LEVEL;
      end else begin
        res_kind  = KIND_READ;
        res_addr  = {cmd.pte_ppn, vpn_of(vaddr_r, cur_lvl - 1'b1), 3'b000};
        level_nxt = cur_lvl - 1'b1;
      end
    end
  end

  // A command that gives a result waits for room in the output register;
  // a dropped one leaves at once.
  assign slot_free = !out_valid_r || out_res.ready;
  assign pop       = cmd_valid && (slot_free || !emit);
  assign cmd_ready = slot_free || !emit;

  always_comb begin
    out_valid_nxt = out_valid_r && !out_res.ready;
    out_kind_nxt  = out_kind_r;
    out_addr_nxt  = out_addr_r;
    out_lvl_nxt   = out_lvl_r;
    if (pop && emit) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = res_kind;
      out_addr_nxt  = res_addr;
      out_lvl_nxt   = res_lvl;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      vaddr_r     <= '0;
      level_r     <= TOP_LEVEL;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        busy_r  <= busy_nxt;
        vaddr_r <= vaddr_nxt;
        level_r <= level_nxt;
      end
    end
    out_kind_r <= out_kind_nxt;
    out_addr_r <= out_addr_nxt;
    out_lvl_r  <= out_lvl_nxt;
  end

  assign out_res.valid      = out_valid_r;
  assign out_res.kind       = out_kind_r;
  assign out_res.address    = out_addr_r;
  assign out_res.leaf_level = out_lvl_r;

  // An idle walker always sits at the top level.
  a_idle_top: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> level_r == TOP_LEVEL)
    else $error("idle walker not at top level");

  // Only a completion carries a non-zero leaf level, and a fault no address.
  a_lvl_only_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_kind_r != KIND_DONE |-> out_lvl_r == '0)
    else $error("leaf level on a non-completion result");

  a_fault_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_kind_r == KIND_FAULT |-> out_addr_r == '0)
    else $error("fault result carries an address");

  // Finishing a walk returns to idle; issuing a read keeps the walk going.
  a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop && emit && res_kind != KIND_READ |=> !busy_r)
    else $error("walker still busy after end of walk");

  a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
    pop && emit && res_kind == KIND_READ |=> busy_r)
    else $error("walker idle after issuing a read");

endmodule

FILE: hw/rtl/sv39_page_table_walker.sv
// Sv39 page table walker top level. Each request (a translate or an entry read response)
// is decoded by the front end, passes a short queue and is executed by the walk engine, so
// a request can be taken every cycle while the result channel keeps up. A request is
// registered in the front end and then in the queue, and its result in the output register.
// The rate is set by the result channel's ready, since a request that gives a result waits
// for the single output register. A translate yields a read request for the top-level
// entry, each valid non-leaf response the next read, and a leaf, an invalid entry or a
// non-leaf at level 0 ends the walk with a completion or fault.
// Translates during a walk and responses while idle are dropped with no result.
module sv39_page_table_walker
  import sv39ptw_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  sv39ptw_in_if.sink    in_req,
  sv39ptw_cfg_if.sink   cfg_wr,
  sv39ptw_out_if.source out_res
);

  logic fr_valid, fr_ready;
  cmd_t fr_cmd;
  logic q_valid, q_ready;
  cmd_t q_cmd;

  // Request decode.
  sv39ptw_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .cmd_valid (fr_valid),
    .cmd       (fr_cmd),
    .cmd_ready (fr_ready)
  );

  // Decoupling queue.
  sv39ptw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fr_valid),
    .push_cmd   (fr_cmd),
    .push_ready (fr_ready),
    .pop_valid  (q_valid),
    .pop_cmd    (q_cmd),
    .pop_ready  (q_ready)
  );

  // Walk engine and result register.
  sv39ptw_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_valid),
    .cmd       (q_cmd),
    .cmd_ready (q_ready),
    .cfg_wr    (cfg_wr),
    .out_res   (out_res)
  );

endmodule

FILE: sim/sv39_walk_checker.sv
// Checker for the Sv39 walker: predicts every result from the observed requests and compares.
`timescale 1ns / 1ps
module sv39_walk_checker
  import sv39ptw_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  sv39ptw_in_if  req_ch,
  sv39ptw_out_if res_ch,
  sv39ptw_cfg_if cfg_ch,
  output int     fail_count,
  output int     results_outstanding,
  output int     reads_seen,
  output int     completions_seen,
  output int     faults_seen,
  output int     dropped_seen
);

  localparam int unsigned PAGE_OFFSET_W = 12;
  localparam int unsigned VPN_W         = 9;
  localparam int unsigned PTE_PPN_LSB   = 10;

  typedef struct packed {
    kind_t              kind;
    logic [PA_W-1:0]    address;
    logic [LEVEL_W-1:0] leaf_level;
  } walk_result_t;

  // Shadow of the walker's state and its one register.
  logic [PPN_W-1:0]   root_ppn;
  logic               walking;
  logic [VA_W-1:0]    walk_vaddr;
  logic [LEVEL_W-1:0] walk_lvl;

  walk_result_t expected_walk_results[$];

  task automatic report_mismatch(input string what);
    $display("[%0t] walker check: %s", $time, what);
    fail_count++;
  endtask

  // Address of the entry indexed by the walked address at the given level.
  function automatic logic [PA_W-1:0] entry_address(input logic [PPN_W-1:0] ppn,
                                                   input logic [LEVEL_W-1:0] lvl);
    logic [VA_W-1:0] shifted;
    shifted = walk_vaddr >> (PAGE_OFFSET_W + VPN_W * lvl);
    return {ppn, 12'h000} + {44'h0, shifted[VPN_W-1:0], 3'b000};
  endfunction

  // Advances the shadow walker by one request and queues the result it gives, if any.
  task automatic predict_walk_step(input mode_t m, input logic [VA_W-1:0] va,
                                   input logic [PTE_W-1:0] pte);
    logic [PPN_W-1:0]   ppn;
    logic [LEVEL_W-1:0] lvl;
    logic [PA_W-1:0]    low_mask;
    walk_result_t       res;
    res = '{kind: KIND_READ, address: '0, leaf_level: '0};
    if (m == MODE_TRANSLATE) begin
      if (walking) begin
        dropped_seen++;
        return;
      end
      walk_vaddr = va;
      walk_lvl = TOP_LEVEL;
      walking = 1'b1;
      res.address = entry_address(root_ppn, TOP_LEVEL);
      expected_walk_results.push_back(res);
      return;
    end
    if (!walking) begin
      dropped_seen++;
      return;
    end
    ppn = pte[PTE_PPN_LSB +: PPN_W];
    lvl = walk_lvl;
    if (lvl > TOP_LEVEL) lvl = TOP_LEVEL;
    if (!pte[0]) begin
      // Invalid entry: the walk ends with a fault.
      walking = 1'b0;
      walk_lvl = TOP_LEVEL;
      res.kind = KIND_FAULT;
    end else if (pte[3:1] != 3'b000) begin
      // Leaf: page offset and lower VPNs come from the virtual address.
      low_mask = (56'd1 << (PAGE_OFFSET_W + VPN_W * lvl)) - 56'd1;
      walking = 1'b0;
      walk_lvl = TOP_LEVEL;
      res.kind = KIND_DONE;
      res.address = ({ppn, 12'h000} & ~low_mask) | ({17'h0, walk_vaddr} & low_mask);
      res.leaf_level = lvl;
    end else if (lvl == 2'd0) begin
      // Pointer entry at the last level is a fault.
      walking = 1'b0;
      walk_lvl = TOP_LEVEL;
      res.kind = KIND_FAULT;
    end else begin
      walk_lvl = lvl - 2'd1;
      res.address = entry_address(ppn, walk_lvl);
    end
    expected_walk_results.push_back(res);
  endtask

  initial begin
    fail_count = 0;
    results_outstanding = 0;
    reads_seen = 0;
    completions_seen = 0;
    faults_seen = 0;
    dropped_seen = 0;
  end

  // Results are compared before the request of the same edge is predicted.
  always @(posedge clk) begin
    walk_result_t exp_res;
    if (!rst_n) begin
      root_ppn = '0;
      walking = 1'b0;
      walk_vaddr = '0;
      walk_lvl = TOP_LEVEL;
      expected_walk_results.delete();
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (expected_walk_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind %0d address %h",
                                    res_ch.kind, res_ch.address));
        end else begin
          exp_res = expected_walk_results.pop_front();
          case (exp_res.kind)
            KIND_READ: reads_seen++;
            KIND_DONE: completions_seen++;
            default:   faults_seen++;
          endcase
          if (res_ch.kind !== exp_res.kind)
            report_mismatch($sformatf("kind %0d, expected %0d", res_ch.kind, exp_res.kind));
          if (res_ch.address !== exp_res.address)
            report_mismatch($sformatf("address %h, expected %h",
                                      res_ch.address, exp_res.address));
          if (res_ch.leaf_level !== exp_res.leaf_level)
            report_mismatch($sformatf("leaf level %0d, expected %0d",
                                      res_ch.leaf_level, exp_res.leaf_level));
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) root_ppn = cfg_ch.root_table_ppn;
      if (req_ch.valid && req_ch.ready)
        predict_walk_step(mode_t'(req_ch.mode), req_ch.virtual_address, req_ch.pte_word);
    end
    results_outstanding = expected_walk_results.size();
  end

endmodule

FILE: sim/sv39_page_table_walker_test.sv
// Test top for the Sv39 walker: clock, reset, request and register stimulus, and the verdict.
`timescale 1ns / 1ps
module sv39_page_table_walker_test;
  import sv39ptw_pkg::*;

  localparam int CYCLE_LIMIT     = 100000;
  localparam int WALKS_PER_PHASE = 240;
  localparam int LONG_HOLD       = 100;
  localparam int SETTLE_CYCLES   = 10;

  logic clk;
  logic rst_n;

  sv39ptw_in_if  req_ch ();
  sv39ptw_out_if res_ch ();
  sv39ptw_cfg_if cfg_ch ();

  int fail_count;
  int results_outstanding;
  int reads_seen;
  int completions_seen;
  int faults_seen;
  int dropped_seen;

  // Stimulus controls shared with the result side, and run counters.
  bit calm;
  int hold_requests;
  int cycle_count;
  int root_writes;

  sv39_page_table_walker u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_ch),
    .cfg_wr  (cfg_ch),
    .out_res (res_ch)
  );

  sv39_walk_checker u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .req_ch              (req_ch),
    .res_ch              (res_ch),
    .cfg_ch              (cfg_ch),
    .fail_count          (fail_count),
    .results_outstanding (results_outstanding),
    .reads_seen          (reads_seen),
    .completions_seen    (completions_seen),
    .faults_seen         (faults_seen),
    .dropped_seen        (dropped_seen)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog on the whole run.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Result side: random back-pressure, with long holds on request from the stimulus.
  initial begin
    int hold_left;
    int holds_served;
    hold_left = 0;
    holds_served = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (holds_served < hold_requests) begin
        holds_served++;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else if (calm) begin
        res_ch.ready <= 1'b1;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= 12);
      end
    end
  end

  function automatic logic [PTE_W-1:0] random_word();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [VA_W-1:0] random_vaddr();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[VA_W-1:0];
  endfunction

  // Valid pointer entry: V set, R, W and X clear, everything else random.
  function automatic logic [PTE_W-1:0] pointer_entry();
    logic [PTE_W-1:0] w;
    w = random_word();
    w[3:1] = 3'b000;
    w[0] = 1'b1;
    return w;
  endfunction

  // Valid leaf entry with at least one of R, W and X.
  function automatic logic [PTE_W-1:0] leaf_entry();
    logic [PTE_W-1:0] w;
    w = random_word();
    w[0] = 1'b1;
    if (w[3:1] == 3'b000) w[$urandom_range(3, 1)] = 1'b1;
    return w;
  endfunction

  // Offers one request, after a random gap unless in a calm stretch.
  task automatic send_request(input mode_t m, input logic [VA_W-1:0] va,
                              input logic [PTE_W-1:0] pte);
    if (!calm && $urandom_range(99) < 12) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(2, 1)) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.mode <= m;
    req_ch.virtual_address <= va;
    req_ch.pte_word <= pte;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  // Stops offering and waits for every predicted result to arrive.
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (results_outstanding != 0) @(posedge clk);
  endtask

  // Writes the root table register once the walker has gone quiet.
  task automatic write_root(input logic [PPN_W-1:0] ppn);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.root_table_ppn <= ppn;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    root_writes++;
  endtask

  // One well-formed walk: translate, zero to two pointer entries, then an ending entry.
  task automatic run_walk(output int sent);
    int depth;
    int pick;
    depth = $urandom_range(2);
    pick = $urandom_range(9);
    send_request(MODE_TRANSLATE, random_vaddr(), random_word());
    for (int i = 0; i < depth; i++)
      send_request(MODE_RESPONSE, random_vaddr(), pointer_entry());
    if (pick < 6)
      send_request(MODE_RESPONSE, random_vaddr(), leaf_entry());
    else if (pick < 8 || depth < 2)
      send_request(MODE_RESPONSE, random_vaddr(), random_word() & ~64'h1);
    else
      send_request(MODE_RESPONSE, random_vaddr(), pointer_entry());
    sent = depth + 2;
  endtask

  // Stray traffic: lone responses, lone translates and walks cut short.
  task automatic run_noise();
    case ($urandom_range(2))
      0: send_request(MODE_RESPONSE, random_vaddr(), random_word());
      1: send_request(MODE_TRANSLATE, random_vaddr(), random_word());
      default: begin
        send_request(MODE_TRANSLATE, random_vaddr(), random_word());
        send_request(MODE_RESPONSE, random_vaddr(), pointer_entry());
      end
    endcase
  endtask

  initial begin
    logic [PPN_W-1:0] phase_root;
    int walked;
    int sent;
    bit held;
    bit paused;
    req_ch.valid = 1'b0;
    req_ch.mode = 1'b0;
    req_ch.virtual_address = '0;
    req_ch.pte_word = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.root_table_ppn = '0;
    calm = 1'b0;
    hold_requests = 0;
    root_writes = 0;
    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, first on the reset root: stray response, busy translate, invalid entry.
    send_request(MODE_RESPONSE, '0, '1);
    send_request(MODE_TRANSLATE, '0, '0);
    send_request(MODE_TRANSLATE, '1, '0);
    send_request(MODE_RESPONSE, '0, 64'hFFFF_FFFF_FFFF_FFFE);
    // Gigapage leaf with every reserved bit set.
    send_request(MODE_TRANSLATE, '1, '0);
    send_request(MODE_RESPONSE, '0, '1);

    // Largest root; pointers with the largest and smallest PPN, then a pointer at level 0.
    write_root('1);
    send_request(MODE_TRANSLATE, 39'h55_5555_5555, '0);
    send_request(MODE_RESPONSE, '0, 64'h003F_FFFF_FFFF_FC01);
    send_request(MODE_RESPONSE, '0, 64'hFFC0_0000_0000_0001);
    send_request(MODE_RESPONSE, '0, 64'h0000_0000_0000_0001);
    // Megapage leaf, read only.
    send_request(MODE_TRANSLATE, 39'h2A_AAAA_AAAA, '0);
    send_request(MODE_RESPONSE, '0, 64'h0015_5555_5555_5401);
    send_request(MODE_RESPONSE, '0, 64'h002A_AAAA_AAAA_A803);
    // Small page leaf, execute only.
    send_request(MODE_TRANSLATE, '1, '0);
    send_request(MODE_RESPONSE, '0, 64'h0000_0000_0000_0401);
    send_request(MODE_RESPONSE, '0, 64'h003F_FFFF_FFFF_FC01);
    send_request(MODE_RESPONSE, '0, 64'h003F_FFFF_FFFF_FC09);
    // Gigapage leaf, write only, with no alignment of the PPN.
    send_request(MODE_TRANSLATE, '0, '0);
    send_request(MODE_RESPONSE, '0, 64'h003F_FFFF_FFFF_FC05);

    // Random phases, each under its own root setting.
    held = 1'b0;
    paused = 1'b0;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       phase_root = '0;
        1:       phase_root = '1;
        default: phase_root = PPN_W'({$urandom, $urandom});
      endcase
      write_root(phase_root);
      calm = (phase == 3);
      walked = 0;
      while (walked < WALKS_PER_PHASE) begin
        if ($urandom_range(99) < 80) begin
          run_walk(sent);
          walked += sent;
        end else begin
          run_noise();
        end
        if (phase == 3 && walked >= 150) calm = 1'b0;
        // Long hold on the result side while requests keep coming.
        if (phase == 1 && !held && walked >= 100) begin
          held = 1'b1;
          hold_requests++;
        end
        // Pause until every outstanding result is back.
        if (phase == 2 && !paused && walked >= 100) begin
          paused = 1'b1;
          wait_drained();
        end
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES * 2) @(posedge clk);
    $display("Covered %0d entry reads, %0d completions and %0d faults; %0d requests dropped.",
             reads_seen, completions_seen, faults_seen, dropped_seen);
    $display("Root table register written %0d times, including both extremes.", root_writes);
    if (fail_count == 0 && results_outstanding == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
